### hw/rtl/clipped_sprite_blit_colour_map_core_assert.svh
// Assertion macros for the sprite blitter, clocked on aclk with reset aresetn.
`ifndef CLIPPED_SPRITE_BLIT_COLOUR_MAP_CORE_ASSERT_SVH
`define CLIPPED_SPRITE_BLIT_COLOUR_MAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define CSBCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define CSBCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSBCM_ASSERT_SAME(label, ante, cons, msg)
`define CSBCM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hw/rtl/csbcm_pkg.sv
// Shared types and constants for the clipped sprite blitter.
`default_nettype none
package csbcm_pkg;

    localparam int DIM_BITS    = 12;
    localparam int POS_BITS    = DIM_BITS + 1;
    localparam int ORG_BITS    = DIM_BITS + 2;
    localparam int ADDR_BITS   = 24;
    localparam int COLOUR_BITS = 8;
    localparam int MAP_ENTRIES = 5;
    localparam int MAP_BITS    = MAP_ENTRIES * COLOUR_BITS;
    localparam int IDX_BITS    = 3;
    localparam int S_DATA_BITS = 88;
    localparam int M_DATA_BITS = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DIM_BITS-1:0] PITCH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] CLIP_W_RESET = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] CLIP_H_RESET = DIM_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEST_PITCH  = 2'd0,
        CFG_CLIP_WIDTH  = 2'd1,
        CFG_CLIP_HEIGHT = 2'd2,
        CFG_COLOUR_MAP  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    // Colour indices of special meaning.
    localparam logic [COLOUR_BITS-1:0] IDX_TRANSPARENT = '0;
    localparam logic [COLOUR_BITS-1:0] IDX_LAST        = COLOUR_BITS'(MAP_ENTRIES - 1);

    // Input item payload, first field in the lowest bits.
    typedef struct packed {
        logic [4:0]             pad;
        logic [COLOUR_BITS-1:0] pixel;
        logic                   opaque;
        logic [DIM_BITS-1:0]    hot_y;
        logic [DIM_BITS-1:0]    hot_x;
        logic [DIM_BITS-1:0]    sprite_height;
        logic [DIM_BITS-1:0]    sprite_width;
        logic [POS_BITS-1:0]    pos_y;
        logic [POS_BITS-1:0]    pos_x;
    } s_data_t;

    // Result item payload.
    typedef struct packed {
        logic [COLOUR_BITS-1:0] colour;
        logic [ADDR_BITS-1:0]   address;
    } m_data_t;

endpackage
`default_nettype wire

### hw/rtl/clipped_sprite_blit_colour_map_core.sv
// Clipped sprite blitter: sprite header and pixel stream in, frame-buffer writes out.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata header or pixel
//  m_       | out       | m_tvalid/m_tready  | m_tdata address, colour
//  cfg_     | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One item is taken per cycle while the m_ side is not stalled; a drawn pixel is registered in
// the pixel stage and then in the output register (clip and index check in the input cycle,
// multiply-add and colour lookup into the output register). The pitch multiply sets the clock path.
// aresetn is synchronous: sprite state and both valid flags clear, registers reload defaults.
// A stalled m_ side fills the two stages, then s_tready drops; nothing is lost.
`default_nettype none
`include "clipped_sprite_blit_colour_map_core_assert.svh"

module clipped_sprite_blit_colour_map_core
    import csbcm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [MAP_BITS-1:0]     cfg_wdata,
    // Input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // pos_x, pos_y, sprite_width, sprite_height, hot_x, hot_y, opaque, pixel, zero pad
    input  wire logic [S_DATA_BITS-1:0]  s_tdata,
    // opcode
    input  wire logic                    s_tuser,
    // Result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // address, colour
    output logic [M_DATA_BITS-1:0]       m_tdata
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [DIM_BITS-1:0] dest_pitch_reg;
    logic [DIM_BITS-1:0] clip_width_reg;
    logic [DIM_BITS-1:0] clip_height_reg;
    logic [MAP_BITS-1:0] colour_map_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_pitch_reg  <= PITCH_RESET;
            clip_width_reg  <= CLIP_W_RESET;
            clip_height_reg <= CLIP_H_RESET;
            colour_map_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEST_PITCH:  dest_pitch_reg  <= cfg_wdata[DIM_BITS-1:0];
                CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_wdata[DIM_BITS-1:0];
                CFG_CLIP_HEIGHT: clip_height_reg <= cfg_wdata[DIM_BITS-1:0];
                CFG_COLOUR_MAP:  colour_map_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: output register and pixel stage each free when empty or draining
    // ---------------------------------------------------------------------
    logic    m_tvalid_reg;
    logic    p1_valid_reg;
    logic    out_ready;
    logic    p1_ready;
    logic    s_accept;
    s_data_t s_data;
    opcode_t s_op;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign p1_ready  = !p1_valid_reg || out_ready;
    assign s_tready  = p1_ready;
    assign s_accept  = s_tvalid && p1_ready;
    assign s_data    = s_data_t'(s_tdata);
    assign s_op      = opcode_t'(s_tuser);

    // ---------------------------------------------------------------------
    // Sprite walk state
    // ---------------------------------------------------------------------
    logic signed [ORG_BITS-1:0] origin_x_reg, origin_x_next;
    logic signed [ORG_BITS-1:0] origin_y_reg, origin_y_next;
    logic [DIM_BITS-1:0]        cur_col_reg, cur_col_next;
    logic [DIM_BITS-1:0]        cur_row_reg, cur_row_next;
    logic [DIM_BITS-1:0]        spr_w_reg, spr_w_next;
    logic [DIM_BITS-1:0]        spr_h_reg, spr_h_next;
    logic                       opaque_mode_reg, opaque_mode_next;
    logic                       active_reg, active_next;

    // Current pixel position on screen; one extra bit for the sum
    logic signed [ORG_BITS:0]   pix_x;
    logic signed [ORG_BITS:0]   pix_y;
    logic                       in_x;
    logic                       in_y;
    logic                       idx_ok;
    logic                       draw;
    logic                       last_col;
    logic                       last_row;

    assign pix_x = {origin_x_reg[ORG_BITS-1], origin_x_reg}
                 + $signed({3'b000, cur_col_reg});
    assign pix_y = {origin_y_reg[ORG_BITS-1], origin_y_reg}
                 + $signed({3'b000, cur_row_reg});

    // Inside the window when not negative and below the clip size
    assign in_x = !pix_x[ORG_BITS] && (pix_x[ORG_BITS-1:0] < {2'b00, clip_width_reg});
    assign in_y = !pix_y[ORG_BITS] && (pix_y[ORG_BITS-1:0] < {2'b00, clip_height_reg});

    // Indices past the map never write; index zero only in opaque mode
    assign idx_ok = (s_data.pixel <= IDX_LAST)
                 && ((s_data.pixel != IDX_TRANSPARENT) || opaque_mode_reg);

    assign draw = active_reg && idx_ok && in_x && in_y;

    assign last_col = ({1'b0, cur_col_reg} + 1'b1) >= {1'b0, spr_w_reg};
    assign last_row = ({1'b0, cur_row_reg} + 1'b1) >= {1'b0, spr_h_reg};

    always_comb begin
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        spr_w_next       = spr_w_reg;
        spr_h_next       = spr_h_reg;
        opaque_mode_next = opaque_mode_reg;
        active_next      = active_reg;
        if (s_accept) begin
            unique case (s_op)
                OP_START: begin
                    // Load the header: top-left corner is hotspot position minus hotspot
                    origin_x_next    = {s_data.pos_x[POS_BITS-1], s_data.pos_x}
                                     - $signed({2'b00, s_data.hot_x});
                    origin_y_next    = {s_data.pos_y[POS_BITS-1], s_data.pos_y}
                                     - $signed({2'b00, s_data.hot_y});
                    spr_w_next       = s_data.sprite_width;
                    spr_h_next       = s_data.sprite_height;
                    opaque_mode_next = s_data.opaque;
                    cur_col_next     = '0;
                    cur_row_next     = '0;
                    // Empty sprite stays inactive
                    active_next      = (s_data.sprite_width != '0)
                                    && (s_data.sprite_height != '0);
                end
                OP_PIXEL: begin
                    // Advance in raster order, clipped or not; drop out after the last
                    if (active_reg) begin
                        if (last_col) begin
                            cur_col_next = '0;
                            cur_row_next = cur_row_reg + 1'b1;
                            if (last_row) begin
                                active_next = 1'b0;
                            end
                        end else begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            spr_w_reg       <= '0;
            spr_h_reg       <= '0;
            opaque_mode_reg <= 1'b0;
            active_reg      <= 1'b0;
        end else begin
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            spr_w_reg       <= spr_w_next;
            spr_h_reg       <= spr_h_next;
            opaque_mode_reg <= opaque_mode_next;
            active_reg      <= active_next;
        end
    end

    // ---------------------------------------------------------------------
    // Pixel stage: holds in-window coordinates and the colour index of a drawn pixel
    // ---------------------------------------------------------------------
    logic                p1_valid_next;
    logic [DIM_BITS-1:0] p1_x_reg;
    logic [DIM_BITS-1:0] p1_y_reg;
    logic [IDX_BITS-1:0] p1_idx_reg;

    assign p1_valid_next = p1_ready ? (s_accept && (s_op == OP_PIXEL) && draw)
                                    : p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready) begin
            p1_x_reg   <= pix_x[DIM_BITS-1:0];
            p1_y_reg   <= pix_y[DIM_BITS-1:0];
            p1_idx_reg <= s_data.pixel[IDX_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Output stage: address = y * pitch + x, colour from the map
    // ---------------------------------------------------------------------
    logic                   m_tvalid_next;
    logic [2*DIM_BITS-1:0]  row_offset;
    m_data_t                m_data_reg;
    m_data_t                m_data_next;

    assign row_offset = p1_y_reg * dest_pitch_reg;

    always_comb begin
        m_data_next.address = ADDR_BITS'(row_offset) + ADDR_BITS'(p1_x_reg);
        unique case (p1_idx_reg)
            3'd0:    m_data_next.colour = colour_map_reg[0*COLOUR_BITS +: COLOUR_BITS];
            3'd1:    m_data_next.colour = colour_map_reg[1*COLOUR_BITS +: COLOUR_BITS];
            3'd2:    m_data_next.colour = colour_map_reg[2*COLOUR_BITS +: COLOUR_BITS];
            3'd3:    m_data_next.colour = colour_map_reg[3*COLOUR_BITS +: COLOUR_BITS];
            3'd4:    m_data_next.colour = colour_map_reg[4*COLOUR_BITS +: COLOUR_BITS];
            default: m_data_next.colour = '0;
        endcase
    end

    assign m_tvalid_next = out_ready ? p1_valid_reg : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `CSBCM_ASSERT_NEXT(a_start_no_result, s_accept && (s_op == OP_START), !p1_valid_reg, "start item produced a pixel")
    `CSBCM_ASSERT_NEXT(a_draw_enters_stage, s_accept && (s_op == OP_PIXEL) && draw, p1_valid_reg, "drawn pixel lost at stage entry")
    `CSBCM_ASSERT_NEXT(a_sprite_ends, s_accept && (s_op == OP_PIXEL) && active_reg && last_col && last_row, !active_reg, "sprite still active after its last pixel")
    `CSBCM_ASSERT_SAME(a_result_from_stage, $rose(m_tvalid_reg), $past(p1_valid_reg), "result appeared without a pixel in the stage")

endmodule
`default_nettype wire
